[rtl/core/ptb_pkg.sv]
// shared types and constants of the sv39 page table builder
// no dependencies; imported by ptb_engine and sv39_page_table_builder_core
package ptb_pkg;

    localparam int POOL_PAGES  = 16;
    localparam int ENTRIES     = 512;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int PG_W        = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int NF_W        = $clog2(POOL_PAGES + 1);
    localparam int ADDR_W      = PG_W + IDX_W;
    localparam int DEPTH       = POOL_PAGES * ENTRIES;

    localparam int PPN_W       = 44;
    localparam int VPN_W       = 27;
    localparam int VA_W        = 39;
    localparam int PA_W        = 56;
    localparam int CNT_W       = 21;
    localparam int PERM_W      = 5;
    localparam int RP_W        = 4;
    localparam int STAT_W      = 2;
    localparam int USED_W      = 5;
    localparam int WORD_W      = 64;
    localparam int PG_OFS_W    = 12;
    localparam int PTE_PPN_LSB = 10;

    localparam logic CMD_MAP  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_POOL_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_OUT_POOL  = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [VA_W-1:0]   virt_addr;
        logic [PA_W-1:0]   phys_addr;
        logic [CNT_W-1:0]  page_count;
        logic [PERM_W-1:0] perm_bits;
        logic [RP_W-1:0]   read_page;
        logic [IDX_W-1:0]  read_entry;
    } t_ptb_in;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  pages_mapped;
        logic [USED_W-1:0] tables_used;
        logic [WORD_W-1:0] word_out;
    } t_ptb_out;

    typedef struct packed {
        logic start;
        logic res_ready;
    } t_ptb_req;

    typedef struct packed {
        logic ready;
        logic done;
    } t_ptb_stat;

endpackage

[rtl/core/sv39_page_table_builder_core.sv]
// top level of the sv39 page table builder: channels, config register, result register
// depends on ptb_pkg and ptb_engine
//
// usage:
//   command beats enter on i_in_valid / o_in_stall as t_ptb_in, one result beat
//   per command leaves on o_out_valid / i_out_stall as t_ptb_out
//   the pool base ppn is written on i_cfg_valid / o_cfg_ready, by the user only while
//   idle, not enforced by the block; one command at a time, o_in_stall high until idle
// sequencing, set by the single-port table memory and the walk sequencer:
//   read command: issue the table read, take the word, then the result beat
//   map command: per page, a table read and check at each of two levels and a leaf
//     write; each new table is first cleared (all 512 entries) and then linked
//   zero page count or read outside the pool: straight to the result beat
// reset: the whole table memory is cleared, one word per cycle, all
//   POOL_PAGES * 512 words (8192); o_in_stall stays high until it ends
// a stalled result beat stays in the output register; the engine may finish
//   the next command and then holds its result until that register frees
module sv39_page_table_builder_core
    import ptb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_ptb_in          i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_ptb_out         o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [PPN_W-1:0] i_cfg_data
);

    logic [PPN_W-1:0] r_pool_base;
    logic             r_out_valid;
    t_ptb_out         r_out_data;

    t_ptb_req         w_req;
    t_ptb_stat        w_stat;
    t_ptb_out         w_res;

    assign w_req.start     = i_in_valid && w_stat.ready;
    assign w_req.res_ready = !r_out_valid || !i_out_stall;

    ptb_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pool_base (r_pool_base),
        .i_req       (w_req),
        .i_item      (i_in_data),
        .o_stat      (w_stat),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_pool_base <= i_cfg_data;
            end
            if (w_stat.done) begin
                r_out_valid <= 1'b1;
                r_out_data  <= w_res;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !w_stat.ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[rtl/core/ptb_engine.sv]
// table memory, walk sequencer and shared 44-bit adder of the page table builder
// depends on ptb_pkg
module ptb_engine
    import ptb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [PPN_W-1:0] i_pool_base,
    input  t_ptb_req         i_req,
    input  t_ptb_in          i_item,
    output t_ptb_stat        o_stat,
    output t_ptb_out         o_res
);

    typedef enum logic [3:0] {
        S_CLR_ALL,
        S_IDLE,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_WALK_RD,
        S_WALK_CHK,
        S_CLR_PAGE,
        S_LINK,
        S_LEAF,
        S_DONE
    } t_state;

    t_state              r_state;
    logic                r_lvl;
    logic [PG_W-1:0]     r_page;
    logic [VPN_W-1:0]    r_vpn;
    logic [PPN_W-1:0]    r_ppn;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_mapped;
    logic [PERM_W-1:0]   r_perm;
    logic [NF_W-1:0]     r_next_free;
    logic [ADDR_W-1:0]   r_clr_cnt;
    logic [STAT_W-1:0]   r_status;
    logic [WORD_W-1:0]   r_word;
    logic [RP_W-1:0]     r_rp;
    logic [IDX_W-1:0]    r_re;
    logic [WORD_W-1:0]   r_rd;

    logic [WORD_W-1:0]   mem [DEPTH];

    logic [ADDR_W-1:0]   w_addr;
    logic                w_we;
    logic [WORD_W-1:0]   w_wdata;
    logic [PPN_W-1:0]    w_op_a;
    logic [PPN_W-1:0]    w_op_b;
    logic                w_cin;
    logic [PPN_W-1:0]    w_sum;
    logic [IDX_W-1:0]    w_slot_idx;
    logic [PG_W-1:0]     w_np;
    logic [WORD_W-1:0]   w_leaf;
    logic [CNT_W-1:0]    n_mapped;
    logic [31:0]         w_rp32;
    logic [31:0]         w_nf32;
    logic [31:0]         w_in_rp32;
    logic                w_walk_last;

    assign w_slot_idx  = r_lvl ? r_vpn[2*IDX_W-1:IDX_W] : r_vpn[3*IDX_W-1:2*IDX_W];
    assign w_np        = r_next_free[PG_W-1:0];
    assign w_leaf      = WORD_W'(r_perm) | (WORD_W'(r_ppn) << PTE_PPN_LSB);
    assign n_mapped    = r_mapped + CNT_W'(1);
    assign w_rp32      = 32'(r_rp);
    assign w_in_rp32   = 32'(i_item.read_page);
    assign w_nf32      = 32'(r_next_free);
    assign w_walk_last = r_lvl;

    // shared adder: pointer offset, pointer ppn and leaf ppn step
    always_comb begin
        w_op_a = r_ppn;
        w_op_b = '0;
        w_cin  = 1'b1;
        unique case (r_state)
            S_WALK_CHK: begin
                w_op_a = r_rd[PTE_PPN_LSB +: PPN_W];
                w_op_b = ~i_pool_base;
                w_cin  = 1'b1;
            end
            S_LINK: begin
                w_op_a = i_pool_base;
                w_op_b = PPN_W'(r_next_free);
                w_cin  = 1'b0;
            end
            default: begin
                w_op_a = r_ppn;
                w_op_b = '0;
                w_cin  = 1'b1;
            end
        endcase
    end

    assign w_sum = w_op_a + w_op_b + PPN_W'(w_cin);

    always_comb begin
        w_addr  = {r_page, w_slot_idx};
        w_we    = 1'b0;
        w_wdata = '0;
        unique case (r_state)
            S_CLR_ALL: begin
                w_addr = r_clr_cnt;
                w_we   = 1'b1;
            end
            S_RD_ISSUE: begin
                w_addr = {w_rp32[PG_W-1:0], r_re};
            end
            S_CLR_PAGE: begin
                w_addr = {w_np, r_clr_cnt[IDX_W-1:0]};
                w_we   = 1'b1;
            end
            S_LINK: begin
                w_we    = 1'b1;
                w_wdata = (WORD_W'(w_sum) << PTE_PPN_LSB) | WORD_W'(1);
            end
            S_LEAF: begin
                w_addr  = {r_page, r_vpn[IDX_W-1:0]};
                w_we    = 1'b1;
                w_wdata = w_leaf;
            end
            default: begin
                w_addr = {r_page, w_slot_idx};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_addr] <= w_wdata;
        end
        r_rd <= mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR_ALL;
            r_clr_cnt   <= '0;
            r_next_free <= NF_W'(1);
            r_lvl       <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLR_ALL: begin
                    r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
                    if (r_clr_cnt == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.start) begin
                        r_status <= ST_OK;
                        r_mapped <= '0;
                        r_word   <= '0;
                        r_rp     <= i_item.read_page;
                        r_re     <= i_item.read_entry;
                        r_vpn    <= i_item.virt_addr[PG_OFS_W +: VPN_W];
                        r_ppn    <= i_item.phys_addr[PG_OFS_W +: PPN_W];
                        r_count  <= i_item.page_count;
                        r_perm   <= i_item.perm_bits;
                        r_lvl    <= 1'b0;
                        r_page   <= '0;
                        if (i_item.cmd == CMD_READ) begin
                            if (w_in_rp32 < 32'(POOL_PAGES)) begin
                                r_state <= S_RD_ISSUE;
                            end else begin
                                r_status <= ST_OUT_POOL;
                                r_state  <= S_DONE;
                            end
                        end else if (i_item.page_count == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_WALK_RD;
                        end
                    end
                end
                S_RD_ISSUE: begin
                    r_state <= S_RD_WAIT;
                end
                S_RD_WAIT: begin
                    r_word  <= r_rd;
                    r_state <= S_DONE;
                end
                S_WALK_RD: begin
                    r_state <= S_WALK_CHK;
                end
                S_WALK_CHK: begin
                    if (!r_rd[0]) begin
                        if (r_next_free >= NF_W'(POOL_PAGES)) begin
                            r_status <= ST_POOL_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_clr_cnt <= '0;
                            r_state   <= S_CLR_PAGE;
                        end
                    end else if (w_sum >= PPN_W'(POOL_PAGES)) begin
                        r_status <= ST_OUT_POOL;
                        r_state  <= S_DONE;
                    end else begin
                        r_page  <= w_sum[PG_W-1:0];
                        r_lvl   <= 1'b1;
                        r_state <= w_walk_last ? S_LEAF : S_WALK_RD;
                    end
                end
                S_CLR_PAGE: begin
                    r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
                    if (r_clr_cnt[IDX_W-1:0] == IDX_W'(ENTRIES - 1)) begin
                        r_state <= S_LINK;
                    end
                end
                S_LINK: begin
                    r_next_free <= r_next_free + NF_W'(1);
                    r_page      <= w_np;
                    r_lvl       <= 1'b1;
                    r_state     <= w_walk_last ? S_LEAF : S_WALK_RD;
                end
                S_LEAF: begin
                    r_word   <= w_leaf;
                    r_mapped <= n_mapped;
                    r_vpn    <= r_vpn + VPN_W'(1);
                    r_ppn    <= w_sum;
                    r_lvl    <= 1'b0;
                    r_page   <= '0;
                    r_state  <= (n_mapped == r_count) ? S_DONE : S_WALK_RD;
                end
                S_DONE: begin
                    if (i_req.res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat.ready = (r_state == S_IDLE);
    assign o_stat.done  = (r_state == S_DONE) && i_req.res_ready;

    assign o_res.status       = r_status;
    assign o_res.pages_mapped = r_mapped;
    assign o_res.tables_used  = w_nf32[USED_W-1:0];
    assign o_res.word_out     = r_word;

endmodule
